// ===== sv/dcd_pkg.sv =====
// Package for the day count to calendar date block.
// Holds the controller state type, command/status structs and month table.
// No dependencies.
package dcd_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_DONE
  } dcd_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture a new day count
    logic year_step;   // take one whole year off the rest
    logic month_step;  // take one whole month off the rest
    logic out_load;    // move the finished date into the output register
  } dcd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic year_done;   // rest is shorter than the current year
    logic month_done;  // rest is inside the current month
  } dcd_sts_t;

  // Widths fixed by the item fields
  localparam int unsigned DAY_COUNT_W = 16;
  localparam int unsigned YEAR_W      = 12;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DOM_W       = 5;
  localparam int unsigned YLEN_W      = 9;

  // Month indexes (0 = January)
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd11;

  // Common-year length and leap-rule counter widths
  localparam logic [YLEN_W-1:0] DAYS_COMMON_YEAR = 9'd365;
  localparam int unsigned C100_W = 7;
  localparam int unsigned C400_W = 9;
  localparam logic [C100_W-1:0] C100_LAST = 7'd99;
  localparam logic [C400_W-1:0] C400_LAST = 9'd399;

  // Length of a month in a common year
  function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] mon);
    logic [DOM_W-1:0] len;
    unique case (mon)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/day_count_to_calendar_date.sv =====
// Day count to Gregorian date: after an accept, Y year steps and M month steps precede out_valid,
// Y = whole years taken off (0..179), M = whole months taken off (0..11).
// One item at a time; the year-by-year subtract loop sets the rate.
// A new item is accepted while the previous result waits in the output register.
// rst_n is synchronous, active low; it clears the controller and out_valid.
module day_count_to_calendar_date #(
  parameter int unsigned EPOCH_YEAR = 1997
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dcd_pkg::DAY_COUNT_W-1:0] in_day_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dcd_pkg::YEAR_W-1:0]      out_year,
  output logic [dcd_pkg::MONTH_W-1:0]     out_month,
  output logic [dcd_pkg::DOM_W-1:0]       out_day_of_month
);

  dcd_pkg::dcd_cmd_t cmd;
  dcd_pkg::dcd_sts_t sts;

  // Controller
  dcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  dcd_dp #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_dp (
    .clk              (clk),
    .in_day_count     (in_day_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month)
  );

`ifndef SYNTHESIS
  // After an accept the block is not ready in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after accepting an item");

  // A result never appears the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Delivered month and day are in range
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month != 5'd0))
    else $error("month or day out of range");

  // Delivered year never precedes the epoch
  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_year >= dcd_pkg::YEAR_W'(EPOCH_YEAR)))
    else $error("year before epoch");
`endif

endmodule

// ===== sv/dcd_ctrl.sv =====
// Controller for the day count to calendar date block.
// Sequences load, year steps, month steps and output handoff.
// Depends on dcd_pkg.
module dcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dcd_pkg::dcd_sts_t sts,
  output dcd_pkg::dcd_cmd_t cmd
);

  dcd_pkg::dcd_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Output register can take a new item when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      dcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dcd_pkg::ST_YEARS;
        end
      end
      dcd_pkg::ST_YEARS: begin
        if (sts.year_done) begin
          state_nxt = dcd_pkg::ST_MONTHS;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      dcd_pkg::ST_MONTHS: begin
        if (sts.month_done) begin
          state_nxt = dcd_pkg::ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      dcd_pkg::ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = dcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dcd_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/dcd_dp.sv =====
// Datapath for the day count to calendar date block.
// Holds the remaining day count, year with leap-rule counters, month, output register.
// Depends on dcd_pkg.
module dcd_dp #(
  parameter int unsigned EPOCH_YEAR = 1997
) (
  input  logic                                clk,
  input  logic [dcd_pkg::DAY_COUNT_W-1:0]     in_day_count,
  input  dcd_pkg::dcd_cmd_t                   cmd,
  output dcd_pkg::dcd_sts_t                   sts,
  output logic [dcd_pkg::YEAR_W-1:0]          out_year,
  output logic [dcd_pkg::MONTH_W-1:0]         out_month,
  output logic [dcd_pkg::DOM_W-1:0]           out_day_of_month
);

  localparam logic [dcd_pkg::YEAR_W-1:0] YEAR_INIT = dcd_pkg::YEAR_W'(EPOCH_YEAR);
  localparam logic [dcd_pkg::C100_W-1:0] C100_INIT = dcd_pkg::C100_W'(EPOCH_YEAR % 100);
  localparam logic [dcd_pkg::C400_W-1:0] C400_INIT = dcd_pkg::C400_W'(EPOCH_YEAR % 400);

  logic [dcd_pkg::DAY_COUNT_W-1:0] rest_r, rest_nxt;
  logic [dcd_pkg::YEAR_W-1:0]      yr_r, yr_nxt;
  logic [dcd_pkg::C100_W-1:0]      c100_r, c100_nxt;
  logic [dcd_pkg::C400_W-1:0]      c400_r, c400_nxt;
  logic [dcd_pkg::MONTH_W-1:0]     mon_r, mon_nxt;
  logic [dcd_pkg::YEAR_W-1:0]      oyear_r;
  logic [dcd_pkg::MONTH_W-1:0]     omon_r;
  logic [dcd_pkg::DOM_W-1:0]       oday_r;

  logic                            leap;
  logic [dcd_pkg::YLEN_W-1:0]      year_len;
  logic [dcd_pkg::DOM_W-1:0]       mon_len;

  // Leap rule: divisible by 4, and not by 100 unless by 400
  assign leap = (yr_r[1:0] == 2'd0) && ((c100_r != '0) || (c400_r == '0));
  assign year_len = dcd_pkg::DAYS_COMMON_YEAR + dcd_pkg::YLEN_W'(leap);
  assign mon_len  = dcd_pkg::month_len(mon_r)
                  + dcd_pkg::DOM_W'(leap && (mon_r == dcd_pkg::MON_FEB));

  // Status compares
  assign sts.year_done  = rest_r < dcd_pkg::DAY_COUNT_W'(year_len);
  assign sts.month_done = (mon_r == dcd_pkg::MON_DEC)
                        || (rest_r < dcd_pkg::DAY_COUNT_W'(mon_len));

  // Working register updates
  always_comb begin
    rest_nxt = rest_r;
    yr_nxt   = yr_r;
    c100_nxt = c100_r;
    c400_nxt = c400_r;
    mon_nxt  = mon_r;
    if (cmd.load) begin
      rest_nxt = in_day_count;
      yr_nxt   = YEAR_INIT;
      c100_nxt = C100_INIT;
      c400_nxt = C400_INIT;
      mon_nxt  = '0;
    end else if (cmd.year_step) begin
      rest_nxt = rest_r - dcd_pkg::DAY_COUNT_W'(year_len);
      yr_nxt   = yr_r + 1'b1;
      c100_nxt = (c100_r == dcd_pkg::C100_LAST) ? '0 : c100_r + 1'b1;
      c400_nxt = (c400_r == dcd_pkg::C400_LAST) ? '0 : c400_r + 1'b1;
    end else if (cmd.month_step) begin
      rest_nxt = rest_r - dcd_pkg::DAY_COUNT_W'(mon_len);
      mon_nxt  = mon_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rest_r <= rest_nxt;
    yr_r   <= yr_nxt;
    c100_r <= c100_nxt;
    c400_r <= c400_nxt;
    mon_r  <= mon_nxt;
  end

  // Output register, loaded once the date is complete
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oyear_r <= yr_r;
      omon_r  <= mon_r + 1'b1;
      oday_r  <= rest_r[dcd_pkg::DOM_W-1:0] + 1'b1;
    end
  end

  assign out_year         = oyear_r;
  assign out_month        = omon_r;
  assign out_day_of_month = oday_r;

endmodule
